[hdl/julia_escape_time_pixel_top_assert.svh]
// Assertion macros for the Julia escape-time pixel engine.
`ifndef JULIA_ESCAPE_TIME_PIXEL_TOP_ASSERT_SVH
`define JULIA_ESCAPE_TIME_PIXEL_TOP_ASSERT_SVH

// Checks a condition at every clock edge outside reset.
`define JETP_CHECK_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define JETP_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/jetp_pkg.sv]
// Shared constants for the Julia escape-time pixel engine.
package jetp_pkg;

  localparam int DATA_W          = 32;
  localparam int MAXIT_W         = 16;
  localparam int ITER_OUT_W      = 16;
  localparam int COLOR_W         = 8;
  localparam int CFG_IDX_W       = 2;

  localparam int FRAC_BITS_DEF   = 28;
  localparam int COUNT_BITS_DEF  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_C_REAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_C_IMAG   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 2'd2;

  localparam logic [MAXIT_W-1:0] MAX_ITER_RESET = 16'd255;

  localparam int BLUE_OFFSET  = 1200;
  localparam int GREEN_OFFSET = 600;

endpackage

[hdl/julia_escape_time_pixel_top.sv]
// Julia escape-time pixel engine built around one shared partial-product multiplier.

// The engine takes one item, a starting point z0 in signed Q4.28, and iterates
// z = z*z + c until |z|^2 reaches 4 or the count reaches max_iter, then returns
// the count and three color bytes. It works on one item at a time and is not
// ready while it iterates. In every iteration the three products x*x, y*y and
// x*y are each built from four partial products through a single shared
// multiplier, followed by one step to drain the multiplier register, one to
// test the magnitude and update z, and one to test the limit. The next item can
// be taken once the result of the last one is loaded into the output register.
// The default limit is 255. A finished result waits in an output register, so
// the next item is accepted while the result is still waiting to be taken.
// Configuration is written through cfg_we, cfg_index and cfg_wdata; the user
// must write it only while the engine is idle, which the block does not enforce.
`include "julia_escape_time_pixel_top_assert.svh"

module julia_escape_time_pixel_top #(
  parameter int FRAC_BITS  = jetp_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS = jetp_pkg::COUNT_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [jetp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [jetp_pkg::DATA_W-1:0]            cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [jetp_pkg::DATA_W-1:0]     in_start_real,
  input  logic signed [jetp_pkg::DATA_W-1:0]     in_start_imag,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [jetp_pkg::ITER_OUT_W-1:0]        out_iter_count,
  output logic [jetp_pkg::COLOR_W-1:0]           out_chan_blue,
  output logic [jetp_pkg::COLOR_W-1:0]           out_chan_green,
  output logic [jetp_pkg::COLOR_W-1:0]           out_chan_red
);

  localparam int ZW   = ((FRAC_BITS + 3 > jetp_pkg::DATA_W) ? FRAC_BITS + 3
                                                            : jetp_pkg::DATA_W) + 2;
  localparam int LO_W = ZW / 2;
  localparam int HI_W = ZW - LO_W;
  localparam int MW   = HI_W + 1;
  localparam int PW   = 2 * MW;
  localparam int AW   = 2 * ZW;
  localparam int LW   = (COUNT_BITS > jetp_pkg::MAXIT_W) ? COUNT_BITS : jetp_pkg::MAXIT_W;

  localparam logic [1:0] G_XX = 2'd0;
  localparam logic [1:0] G_YY = 2'd1;
  localparam logic [1:0] G_XY = 2'd2;

  localparam logic [1:0] P_LL = 2'd0;
  localparam logic [1:0] P_LH = 2'd1;
  localparam logic [1:0] P_HL = 2'd2;
  localparam logic [1:0] P_HH = 2'd3;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_TEST = 6'b000010,
    S_MUL  = 6'b000100,
    S_LAST = 6'b001000,
    S_EVAL = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                    state_r, state_nxt;

  logic signed [jetp_pkg::DATA_W-1:0] c_real_r, c_imag_r;
  logic [jetp_pkg::MAXIT_W-1:0]       max_iter_r;

  logic signed [ZW-1:0]      x_r, y_r;
  logic [COUNT_BITS-1:0]     count_r, limit_r;
  logic [1:0]                group_r, piece_r;

  logic signed [PW-1:0]      pp_r;
  logic [1:0]                pp_group_r, pp_piece_r;
  logic                      pp_vld_r;

  logic signed [AW-1:0]      mag_r, diff_r, xy_r;

  logic                      out_valid_r;
  logic [COUNT_BITS-1:0]     res_count_r;

  logic signed [ZW-1:0]      op_a, op_b;
  logic signed [MW-1:0]      mul_a, mul_b;
  logic signed [PW-1:0]      mul_p;
  logic signed [AW-1:0]      pp_ext, pp_sh;
  logic [LW-1:0]             lim_ext, lim_max;
  logic                      escaped;

  assign in_ready = (state_r == S_IDLE);

  // Operand pair for the partial product under issue.
  always_comb begin
    op_a = (group_r == G_YY) ? y_r : x_r;
    op_b = (group_r == G_XX) ? x_r : y_r;
    mul_a = piece_r[1] ? {op_a[ZW-1], op_a[ZW-1:LO_W]}
                       : {{(MW-LO_W){1'b0}}, op_a[LO_W-1:0]};
    mul_b = piece_r[0] ? {op_b[ZW-1], op_b[ZW-1:LO_W]}
                       : {{(MW-LO_W){1'b0}}, op_b[LO_W-1:0]};
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    pp_ext = AW'(pp_r);
    case (pp_piece_r)
      P_LL:    pp_sh = pp_ext;
      P_LH:    pp_sh = pp_ext <<< LO_W;
      P_HL:    pp_sh = pp_ext <<< LO_W;
      P_HH:    pp_sh = pp_ext <<< (2 * LO_W);
      default: pp_sh = pp_ext;
    endcase
  end

  assign escaped = |mag_r[AW-1:2*FRAC_BITS+2];

  always_comb begin
    lim_ext = LW'(max_iter_r);
    lim_max = LW'({COUNT_BITS{1'b1}});
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_TEST;
      end
      S_TEST: begin
        state_nxt = (count_r >= limit_r) ? S_DONE : S_MUL;
      end
      S_MUL: begin
        if (group_r == G_XY && piece_r == P_HH) state_nxt = S_LAST;
      end
      S_LAST: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = escaped ? S_DONE : S_TEST;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pp_vld_r    <= 1'b0;
      c_real_r    <= '0;
      c_imag_r    <= '0;
      max_iter_r  <= jetp_pkg::MAX_ITER_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          jetp_pkg::REG_C_REAL:   c_real_r   <= cfg_wdata;
          jetp_pkg::REG_C_IMAG:   c_imag_r   <= cfg_wdata;
          jetp_pkg::REG_MAX_ITER: max_iter_r <= cfg_wdata[jetp_pkg::MAXIT_W-1:0];
          default: ;
        endcase
      end
      pp_vld_r <= (state_r == S_MUL);
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      x_r     <= ZW'(in_start_real);
      y_r     <= ZW'(in_start_imag);
      count_r <= '0;
      limit_r <= (lim_ext > lim_max) ? COUNT_BITS'(lim_max) : COUNT_BITS'(lim_ext);
    end
    if (state_r == S_TEST) begin
      group_r <= G_XX;
      piece_r <= P_LL;
      mag_r   <= '0;
      diff_r  <= '0;
      xy_r    <= '0;
    end
    if (state_r == S_MUL) begin
      pp_r       <= mul_p;
      pp_group_r <= group_r;
      pp_piece_r <= piece_r;
      piece_r    <= piece_r + 2'd1;
      if (piece_r == P_HH) group_r <= group_r + 2'd1;
    end
    if (pp_vld_r) begin
      case (pp_group_r)
        G_XX: begin
          mag_r  <= mag_r + pp_sh;
          diff_r <= diff_r + pp_sh;
        end
        G_YY: begin
          mag_r  <= mag_r + pp_sh;
          diff_r <= diff_r - pp_sh;
        end
        G_XY:    xy_r <= xy_r + pp_sh;
        default: ;
      endcase
    end
    if (state_r == S_EVAL && !escaped) begin
      x_r     <= ZW'(diff_r[FRAC_BITS +: ZW]) + ZW'(c_real_r);
      y_r     <= ZW'(xy_r[FRAC_BITS-1 +: ZW]) + ZW'(c_imag_r);
      count_r <= count_r + COUNT_BITS'(1);
    end
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      res_count_r <= count_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_iter_count = jetp_pkg::ITER_OUT_W'(res_count_r);
  assign out_chan_blue  = jetp_pkg::COLOR_W'(res_count_r)
                          - jetp_pkg::COLOR_W'(jetp_pkg::BLUE_OFFSET);
  assign out_chan_green = jetp_pkg::COLOR_W'(res_count_r)
                          - jetp_pkg::COLOR_W'(jetp_pkg::GREEN_OFFSET);
  assign out_chan_red   = jetp_pkg::COLOR_W'(res_count_r);

  `JETP_CHECK_HOLDS(a_count_in_limit, (state_r == S_IDLE) || (count_r <= limit_r), "Iteration count passed the limit.")
  `JETP_CHECK_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "Engine took a second item while busy.")
  `JETP_CHECK_NEXT(a_result_loaded, (state_r == S_DONE) && (!out_valid_r || out_ready), out_valid_r && (state_r == S_IDLE), "Finished item was not loaded into the output register.")

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the Julia escape-time pixel engine, with its own escape-count predictor.
module testbench;

  localparam int FRAC = jetp_pkg::FRAC_BITS_DEF;
  localparam logic signed [127:0] ESCAPE_SQ = 128'sd1 <<< (2 * FRAC + 2);
  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [jetp_pkg::ITER_OUT_W-1:0] iter_count;
    logic [jetp_pkg::COLOR_W-1:0]    chan_blue;
    logic [jetp_pkg::COLOR_W-1:0]    chan_green;
    logic [jetp_pkg::COLOR_W-1:0]    chan_red;
  } pixel_result_t;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 cfg_we;
  logic [jetp_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic [jetp_pkg::DATA_W-1:0]          cfg_wdata;
  logic                                 in_valid;
  logic                                 in_ready;
  logic signed [jetp_pkg::DATA_W-1:0]   in_start_real;
  logic signed [jetp_pkg::DATA_W-1:0]   in_start_imag;
  logic                                 out_valid;
  logic                                 out_ready;
  logic [jetp_pkg::ITER_OUT_W-1:0]      out_iter_count;
  logic [jetp_pkg::COLOR_W-1:0]         out_chan_blue;
  logic [jetp_pkg::COLOR_W-1:0]         out_chan_green;
  logic [jetp_pkg::COLOR_W-1:0]         out_chan_red;

  logic signed [jetp_pkg::DATA_W-1:0]   c_re;
  logic signed [jetp_pkg::DATA_W-1:0]   c_im;
  logic [jetp_pkg::MAXIT_W-1:0]         iter_lim;

  pixel_result_t               pending_pixels[$];
  int                          errors;
  int                          cycles;
  bit                          idle_on;
  bit                          hold_request;

  julia_escape_time_pixel_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_start_real  (in_start_real),
    .in_start_imag  (in_start_imag),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_iter_count (out_iter_count),
    .out_chan_blue  (out_chan_blue),
    .out_chan_green (out_chan_green),
    .out_chan_red   (out_chan_red)
  );

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = jetp_pkg::REG_C_REAL;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_start_real = '0;
    in_start_imag = '0;
    c_re = '0;
    c_im = '0;
    iter_lim = jetp_pkg::MAX_ITER_RESET;
    errors = 0;
    cycles = 0;
    idle_on = 1'b1;
    hold_request = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Iterates z = z*z + c at full product width and counts iterations before escape.
  function automatic pixel_result_t escape_time(input logic signed [jetp_pkg::DATA_W-1:0] sr,
                                                input logic signed [jetp_pkg::DATA_W-1:0] si);
    logic signed [63:0]  x, y, cr64, ci64;
    logic signed [127:0] wx, wy, xx, yy, xy, nx, ny;
    int                  n;
    bit                  escaped;
    pixel_result_t       r;
    x = 64'(sr);
    y = 64'(si);
    cr64 = 64'(c_re);
    ci64 = 64'(c_im);
    n = 0;
    escaped = 1'b0;
    while (!escaped && n < int'(iter_lim)) begin
      wx = 128'(x);
      wy = 128'(y);
      xx = wx * wx;
      yy = wy * wy;
      if (xx + yy >= ESCAPE_SQ) begin
        escaped = 1'b1;
      end else begin
        xy = wx * wy;
        nx = (xx - yy) >>> FRAC;
        ny = (xy + xy) >>> FRAC;
        x = nx[63:0] + cr64;
        y = ny[63:0] + ci64;
        n++;
      end
    end
    r.iter_count = n[jetp_pkg::ITER_OUT_W-1:0];
    r.chan_blue = jetp_pkg::COLOR_W'(n - jetp_pkg::BLUE_OFFSET);
    r.chan_green = jetp_pkg::COLOR_W'(n - jetp_pkg::GREEN_OFFSET);
    r.chan_red = jetp_pkg::COLOR_W'(n);
    return r;
  endfunction

  // Three in four points lie within [-2, 2]; the rest use the full 32-bit range.
  function automatic logic signed [jetp_pkg::DATA_W-1:0] random_coord();
    logic signed [jetp_pkg::DATA_W-1:0] v;
    if ($urandom_range(0, 3) == 0) begin
      v = $urandom;
    end else begin
      v = $urandom_range(32'h4000_0000, 0);
      v = v - 32'sh2000_0000;
    end
    return v;
  endfunction

  task automatic write_reg(input logic [jetp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [jetp_pkg::DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      jetp_pkg::REG_C_REAL:   c_re = value;
      jetp_pkg::REG_C_IMAG:   c_im = value;
      jetp_pkg::REG_MAX_ITER: iter_lim = value[jetp_pkg::MAXIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic signed [jetp_pkg::DATA_W-1:0] cr,
                            input logic signed [jetp_pkg::DATA_W-1:0] ci,
                            input logic [jetp_pkg::MAXIT_W-1:0] lim);
    write_reg(jetp_pkg::REG_C_REAL, cr);
    write_reg(jetp_pkg::REG_C_IMAG, ci);
    write_reg(jetp_pkg::REG_MAX_ITER,
              {{(jetp_pkg::DATA_W - jetp_pkg::MAXIT_W){1'b0}}, lim});
  endtask

  task automatic send_pixel(input logic signed [jetp_pkg::DATA_W-1:0] sr,
                            input logic signed [jetp_pkg::DATA_W-1:0] si);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_start_real <= sr;
    in_start_imag <= si;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_pixels.push_back(escape_time(sr, si));
  endtask

  task automatic wait_idle;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= rst_n && !(idle_on && $urandom_range(0, 99) < 17);
      end
    end
  end

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    pixel_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: result with no item pending, expected none, got iter_count %0d",
                 $time, out_iter_count);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        compare_field("iter_count", int'(want.iter_count), int'(out_iter_count));
        compare_field("chan_blue", int'(want.chan_blue), int'(out_chan_blue));
        compare_field("chan_green", int'(want.chan_green), int'(out_chan_green));
        compare_field("chan_red", int'(want.chan_red), int'(out_chan_red));
      end
    end
  end

  task automatic test_default_config;
    send_pixel(32'sh0000_0000, 32'sh0000_0000);
    send_pixel(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_pixel(32'sh8000_0000, 32'sh8000_0000);
    send_pixel(32'sh8000_0000, 32'sh0000_0000);
    send_pixel(32'sh0000_0000, 32'sh7FFF_FFFF);
    // Points exactly on the escape circle stop before the first iteration.
    send_pixel(32'sh2000_0000, 32'sh0000_0000);
    send_pixel(32'sh0000_0000, 32'shE000_0000);
    send_pixel(32'sh1FFF_FFFF, 32'sh0000_0000);
    send_pixel(32'sh1000_0000, 32'sh1000_0000);
    wait_idle;
  endtask

  task automatic test_zero_limit;
    set_config(32'sh0000_0000, 32'sh0000_0000, 16'd0);
    send_pixel(32'sh0000_0000, 32'sh0000_0000);
    send_pixel(32'sh1000_0000, 32'shF800_0000);
    send_pixel(random_coord(), random_coord());
    wait_idle;
  endtask

  task automatic test_extreme_constant;
    set_config(32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF);
    send_pixel(32'sh0000_0000, 32'sh0000_0000);
    send_pixel(32'sh7FFF_FFFF, 32'sh8000_0000);
    wait_idle;
    set_config(32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF);
    send_pixel(32'sh0000_0001, 32'shFFFF_FFFF);
    send_pixel(32'shF000_0000, 32'sh0800_0000);
    wait_idle;
  endtask

  // Just past the cusp at c = 0.25 the orbit creeps along the real axis for a long time.
  task automatic test_slow_escape;
    set_config(32'sd67109938, 32'sh0000_0000, 16'hFFFF);
    send_pixel(32'sh0000_0000, 32'sh0000_0000);
    wait_idle;
    set_config(32'sd67109938, 32'sh0000_0000, 16'd1000);
    send_pixel(32'sh0000_0000, 32'sh0000_0000);
    wait_idle;
    set_config(32'sd67135708, 32'sh0000_0000, 16'hFFFF);
    send_pixel(32'sh01999999, 32'shFE666667);
    wait_idle;
  endtask

  task automatic test_output_backpressure;
    set_config(-32'sd214748365, 32'sd41875931, 16'd8);
    idle_on = 1'b0;
    hold_request = 1'b1;
    repeat (24) send_pixel(random_coord(), random_coord());
    wait_idle;
    idle_on = 1'b1;
  endtask

  task automatic test_random_constants;
    logic signed [jetp_pkg::DATA_W-1:0] cr, ci;
    logic [jetp_pkg::MAXIT_W-1:0]       lim;
    int                                 roll;
    for (int p = 0; p < 22; p++) begin
      case ($urandom_range(0, 5))
        0: begin cr = -32'sd214748365; ci = 32'sd41875931; end
        1: begin cr = 32'sd76504105; ci = 32'sd2684355; end
        2: begin cr = -32'sd107374182; ci = 32'sd161061274; end
        3: begin cr = -32'sd188377266; ci = -32'sd103132902; end
        default: begin cr = random_coord(); ci = random_coord(); end
      endcase
      roll = int'($urandom_range(0, 99));
      if (roll < 5) begin
        lim = '0;
      end else if (roll < 10) begin
        lim = 16'd100;
      end else begin
        lim = jetp_pkg::MAXIT_W'($urandom_range(40, 1));
      end
      idle_on = (p != 11);
      set_config(cr, ci, lim);
      repeat (50) send_pixel(random_coord(), random_coord());
      wait_idle;
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_default_config;
    test_zero_limit;
    test_extreme_constant;
    test_slow_escape;
    test_output_backpressure;
    test_random_constants;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[julia_escape_time_pixel_top.f]
+incdir+hdl
hdl/jetp_pkg.sv
hdl/julia_escape_time_pixel_top.sv
tb/sv/testbench.sv
